FILE: src/cacp_pkg.sv
`timescale 1ns / 1ps

package cacp_pkg;

   // Default upper bound on the number of cores the block is built for.
   localparam int MAX_CORES_DEFAULT = 16;

   // Width of the online core mask and of the per-sample arithmetic.
   localparam int MASK_W   = 16;
   localparam int SAMPLE_W = 32;

   // Configuration port geometry.
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 7;

   // Register reset values.
   localparam logic [4:0] MAX_CORES_RESET  = 5'd16;
   localparam logic [4:0] MIN_CORES_RESET  = 5'd1;
   localparam logic [4:0] POSSIBLE_RESET   = 5'd16;
   localparam logic [6:0] INC_MARGIN_RESET = 7'd95;
   localparam logic [6:0] DEC_MARGIN_RESET = 7'd10;

   // Percent scale used by the load computation.
   localparam logic [31:0] PERCENT = 32'd100;

   // Configuration register indexes.
   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_ENABLED        = 3'd0,
      CSR_MAX_CORES      = 3'd1,
      CSR_MIN_CORES      = 3'd2,
      CSR_POSSIBLE_CORES = 3'd3,
      CSR_INC_MARGIN     = 3'd4,
      CSR_DEC_MARGIN     = 3'd5
   } csr_index_type;

   // Result actions.
   typedef enum logic [1:0] {
      ACTION_NONE = 2'd0,
      ACTION_UP   = 2'd1,
      ACTION_DOWN = 2'd2
   } action_type;

   // One sampling tick.
   typedef struct packed {
      logic [63:0] idle_total_us;
      logic [63:0] wall_now_us;
      logic [15:0] online_mask;
      logic        sys_active;
   } req_item_type;

   // One decision.
   typedef struct packed {
      action_type  action;
      logic [3:0]  target_core;
   } rsp_item_type;

endpackage

FILE: src/cpu_count_autoscale_policy.sv
`timescale 1ns / 1ps

// A sampled item goes through the count check, two passes through the shared 32x32
// multiplier, a skip test, a third multiplier pass, a 32-step divider and a compare before
// its result is loaded; disabled, out-of-limit and skipped items go straight to loading.
// Throughput: one item at a time; req_stall stays high until the result is loaded, and
// loading waits while an earlier result is held by rsp_stall.
// Reset (synchronous, active high) restores register defaults and clears the previous samples.
module cpu_count_autoscale_policy #(
   parameter int MaxCores = cacp_pkg::MAX_CORES_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  cacp_pkg::req_item_type            req_item,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output cacp_pkg::rsp_item_type            rsp_item,
   input  logic                              csr_we,
   input  logic [cacp_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [cacp_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   localparam int Window = (MaxCores < cacp_pkg::MASK_W) ? MaxCores : cacp_pkg::MASK_W;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CHECK,
      ST_MUL_SPARE,
      ST_MUL_CAP,
      ST_TEST,
      ST_MUL_PCT,
      ST_DIVIDE,
      ST_COMPARE,
      ST_DONE
   } state_type;

   state_type state_ff, state_in;

   // Configuration registers.
   logic       enabled_ff, enabled_in;
   logic [4:0] max_cores_ff, max_cores_in;
   logic [4:0] min_cores_ff, min_cores_in;
   logic [4:0] possible_ff, possible_in;
   logic [6:0] inc_margin_ff, inc_margin_in;
   logic [6:0] dec_margin_ff, dec_margin_in;

   // Latched item.
   logic [31:0] idle_smp_ff, idle_smp_in;
   logic [31:0] wall_smp_ff, wall_smp_in;
   logic [15:0] mask_ff, mask_in;
   logic        running_ff, running_in;

   // Policy state.
   logic [31:0] last_idle_ff, last_idle_in;
   logic [31:0] last_wall_ff, last_wall_in;
   logic [1:0]  streak_ff, streak_in;

   // Datapath.
   logic [31:0]          w_ff, w_in;
   logic [31:0]          idle_ff, idle_in;
   logic [31:0]          prod_ff, prod_in;
   logic [31:0]          rem_ff, rem_in;
   logic [4:0]           count_ff, count_in;
   cacp_pkg::action_type kind_ff, kind_in;

   // Output register.
   logic                   rsp_valid_ff, rsp_valid_in;
   cacp_pkg::rsp_item_type rsp_item_ff, rsp_item_in;

   logic [15:0] win_mask;
   logic [4:0]  n_cnt;
   logic [4:0]  scan_lim;
   logic        down_found, up_found;
   logic [3:0]  down_idx, up_idx;
   logic [31:0] mul_a, mul_b, mul_p;
   logic [32:0] rem_sh, rem_sub;
   logic signed [11:0] base12;
   logic signed [31:0] base32, lo_thr, hi_thr, load_s;
   logic        req_take, out_free;
   cacp_pkg::rsp_item_type result;

   assign req_stall = (state_ff != ST_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

   // Mask bits beyond the core window are ignored.
   always_comb begin
      for (int i = 0; i < cacp_pkg::MASK_W; i++) begin
         win_mask[i] = (i < Window);
      end
   end

   // Online core count.
   always_comb begin
      n_cnt = 5'd0;
      for (int i = 0; i < cacp_pkg::MASK_W; i++) begin
         n_cnt = n_cnt + {4'd0, mask_ff[i]};
      end
   end

   // Core choice: highest online core for take-down, lowest offline core above 0
   // for bring-up, both within the scan window.
   assign scan_lim = (possible_ff < 5'(Window)) ? possible_ff : 5'(Window);

   always_comb begin
      down_found = 1'b0;
      down_idx   = 4'd0;
      up_found   = 1'b0;
      up_idx     = 4'd0;
      for (int i = 0; i < cacp_pkg::MASK_W; i++) begin
         if ((5'(i) < scan_lim) && mask_ff[i]) begin
            down_found = 1'b1;
            down_idx   = 4'(i);
         end
      end
      for (int i = cacp_pkg::MASK_W - 1; i > 0; i--) begin
         if ((5'(i) < scan_lim) && !mask_ff[i]) begin
            up_found = 1'b1;
            up_idx   = 4'(i);
         end
      end
   end

   // Shared multiplier; only the low word is kept.
   always_comb begin
      case (state_ff)
         ST_MUL_SPARE: begin
            mul_a = w_ff;
            mul_b = {27'd0, possible_ff} - {27'd0, n_cnt};
         end
         ST_MUL_CAP: begin
            mul_a = w_ff;
            mul_b = {27'd0, possible_ff};
         end
         default: begin
            mul_a = prod_ff;
            mul_b = cacp_pkg::PERCENT;
         end
      endcase
   end

   assign mul_p = 32'(mul_a * mul_b);

   // One restoring division step: quotient bits shift into prod_ff.
   assign rem_sh  = {rem_ff, prod_ff[31]};
   assign rem_sub = rem_sh - {1'b0, w_ff};

   // Load bands around (n-1)*100.
   assign base12 = $signed(12'(n_cnt) * 12'd100 - 12'd100);
   assign base32 = {{20{base12[11]}}, base12};
   assign lo_thr = base32 - $signed({25'd0, dec_margin_ff});
   assign hi_thr = base32 + $signed({25'd0, inc_margin_ff});
   assign load_s = $signed(prod_ff);

   // Final decision from the pending request.
   always_comb begin
      result.action      = cacp_pkg::ACTION_NONE;
      result.target_core = 4'd0;
      case (kind_ff)
         cacp_pkg::ACTION_UP: begin
            if (n_cnt != max_cores_ff && up_found) begin
               result.action      = cacp_pkg::ACTION_UP;
               result.target_core = up_idx;
            end
         end
         cacp_pkg::ACTION_DOWN: begin
            if (n_cnt != min_cores_ff && down_found) begin
               result.action      = cacp_pkg::ACTION_DOWN;
               result.target_core = down_idx;
            end
         end
         default: begin
         end
      endcase
   end

   // Next-state logic.
   always_comb begin
      state_in      = state_ff;
      enabled_in    = enabled_ff;
      max_cores_in  = max_cores_ff;
      min_cores_in  = min_cores_ff;
      possible_in   = possible_ff;
      inc_margin_in = inc_margin_ff;
      dec_margin_in = dec_margin_ff;
      idle_smp_in   = idle_smp_ff;
      wall_smp_in   = wall_smp_ff;
      mask_in       = mask_ff;
      running_in    = running_ff;
      last_idle_in  = last_idle_ff;
      last_wall_in  = last_wall_ff;
      streak_in     = streak_ff;
      w_in          = w_ff;
      idle_in       = idle_ff;
      prod_in       = prod_ff;
      rem_in        = rem_ff;
      count_in      = count_ff;
      kind_in       = kind_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_item_in   = rsp_item_ff;

      // Register writes.
      if (csr_we) begin
         unique case (csr_index)
            cacp_pkg::CSR_ENABLED:        enabled_in    = csr_wdata[0];
            cacp_pkg::CSR_MAX_CORES:      max_cores_in  = csr_wdata[4:0];
            cacp_pkg::CSR_MIN_CORES:      min_cores_in  = csr_wdata[4:0];
            cacp_pkg::CSR_POSSIBLE_CORES: possible_in   = csr_wdata[4:0];
            cacp_pkg::CSR_INC_MARGIN:     inc_margin_in = csr_wdata;
            cacp_pkg::CSR_DEC_MARGIN:     dec_margin_in = csr_wdata;
            default: begin
            end
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               idle_smp_in = req_item.idle_total_us[31:0];
               wall_smp_in = req_item.wall_now_us[31:0];
               mask_in     = req_item.online_mask & win_mask;
               running_in  = req_item.sys_active;
               state_in    = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (!(enabled_ff && running_ff)) begin
               kind_in  = cacp_pkg::ACTION_NONE;
               state_in = ST_DONE;
            end else if (n_cnt > max_cores_ff) begin
               kind_in  = cacp_pkg::ACTION_DOWN;
               state_in = ST_DONE;
            end else if (n_cnt < min_cores_ff) begin
               kind_in  = cacp_pkg::ACTION_UP;
               state_in = ST_DONE;
            end else begin
               w_in         = wall_smp_ff - last_wall_ff;
               idle_in      = idle_smp_ff - last_idle_ff;
               last_wall_in = wall_smp_ff;
               last_idle_in = idle_smp_ff;
               state_in     = ST_MUL_SPARE;
            end
         end
         ST_MUL_SPARE: begin
            // Offline cores count as fully idle.
            prod_in  = mul_p;
            state_in = ST_MUL_CAP;
         end
         ST_MUL_CAP: begin
            idle_in  = idle_ff + prod_ff;
            prod_in  = mul_p;
            state_in = ST_TEST;
         end
         ST_TEST: begin
            // Skip the sample on zero wall time or idle above capacity.
            if (w_ff == 32'd0 || prod_ff < idle_ff) begin
               kind_in  = cacp_pkg::ACTION_NONE;
               state_in = ST_DONE;
            end else begin
               prod_in  = prod_ff - idle_ff;
               state_in = ST_MUL_PCT;
            end
         end
         ST_MUL_PCT: begin
            prod_in  = mul_p;
            rem_in   = 32'd0;
            count_in = 5'd0;
            state_in = ST_DIVIDE;
         end
         ST_DIVIDE: begin
            if (!rem_sub[32]) begin
               rem_in  = rem_sub[31:0];
               prod_in = {prod_ff[30:0], 1'b1};
            end else begin
               rem_in  = rem_sh[31:0];
               prod_in = {prod_ff[30:0], 1'b0};
            end
            count_in = count_ff + 5'd1;
            if (count_ff == 5'd31) begin
               state_in = ST_COMPARE;
            end
         end
         ST_COMPARE: begin
            kind_in  = cacp_pkg::ACTION_NONE;
            state_in = ST_DONE;
            if (load_s < lo_thr) begin
               // Low load must persist for four samples before a take-down.
               if (streak_ff != 2'd3) begin
                  streak_in = streak_ff + 2'd1;
               end else begin
                  streak_in = 2'd0;
                  kind_in   = cacp_pkg::ACTION_DOWN;
               end
            end else begin
               streak_in = 2'd0;
               if (load_s > hi_thr) begin
                  kind_in = cacp_pkg::ACTION_UP;
               end
            end
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_item_in  = result;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State, configuration and output registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         enabled_ff    <= 1'b0;
         max_cores_ff  <= cacp_pkg::MAX_CORES_RESET;
         min_cores_ff  <= cacp_pkg::MIN_CORES_RESET;
         possible_ff   <= cacp_pkg::POSSIBLE_RESET;
         inc_margin_ff <= cacp_pkg::INC_MARGIN_RESET;
         dec_margin_ff <= cacp_pkg::DEC_MARGIN_RESET;
         last_idle_ff  <= 32'd0;
         last_wall_ff  <= 32'd0;
         streak_ff     <= 2'd0;
         kind_ff       <= cacp_pkg::ACTION_NONE;
         count_ff      <= 5'd0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         enabled_ff    <= enabled_in;
         max_cores_ff  <= max_cores_in;
         min_cores_ff  <= min_cores_in;
         possible_ff   <= possible_in;
         inc_margin_ff <= inc_margin_in;
         dec_margin_ff <= dec_margin_in;
         last_idle_ff  <= last_idle_in;
         last_wall_ff  <= last_wall_in;
         streak_ff     <= streak_in;
         kind_ff       <= kind_in;
         count_ff      <= count_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      idle_smp_ff <= idle_smp_in;
      wall_smp_ff <= wall_smp_in;
      mask_ff     <= mask_in;
      running_ff  <= running_in;
      w_ff        <= w_in;
      idle_ff     <= idle_in;
      prod_ff     <= prod_in;
      rem_ff      <= rem_in;
      rsp_item_ff <= rsp_item_in;
   end

endmodule

FILE: src/cacp_checker.sv
`timescale 1ns / 1ps

module cacp_checker (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_valid,
   input logic                   req_stall,
   input logic                   rsp_valid,
   input logic                   rsp_stall,
   input cacp_pkg::rsp_item_type rsp_item
);

   // A waiting result holds until it is taken.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_item))
      else $error("result changed while stalled");

   // A result with no action never names a core.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_item.action == cacp_pkg::ACTION_NONE) |-> rsp_item.target_core == 4'd0)
      else $error("idle result carries a core index");

   // The block works on one item at a time.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("new item taken while busy");

   // Reset leaves the block empty and ready.
   assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("block not empty after reset");

endmodule

bind cpu_count_autoscale_policy cacp_checker u_cacp_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_item  (rsp_item)
);
